>>> sv/shti_pkg.sv
// shti_pkg: types and constants for the soft hyphen transition inserter
// no dependencies; imported by soft_hyphen_transition_inserter

package shti_pkg;

	localparam int unsigned CpWidth     = 21;
	localparam int unsigned MaskWidth   = 64;
	localparam int unsigned SetSpan     = 128;
	localparam int unsigned SetIdxWidth = $clog2(SetSpan);
	localparam int unsigned MaxResults  = 4;
	localparam int unsigned CntWidth    = $clog2(MaxResults + 1);
	localparam int unsigned SlotWidth   = $clog2(MaxResults);
	localparam int unsigned CfgIdxWidth = 3;

	typedef logic [CpWidth-1:0] cp_t;

	localparam cp_t ChSpace     = cp_t'(32'h20);
	localparam cp_t ChNewline   = cp_t'(32'h0A);
	localparam cp_t ChBackslash = cp_t'(32'h5C);
	localparam cp_t ChStar      = cp_t'(32'h2A);
	localparam cp_t ChShy       = cp_t'(32'hAD);

	typedef enum logic [CfgIdxWidth-1:0] {
		REG_BLOCK_BASE     = 3'd0,
		REG_FIRST_MASK_LO  = 3'd1,
		REG_FIRST_MASK_HI  = 3'd2,
		REG_SECOND_MASK_LO = 3'd3,
		REG_SECOND_MASK_HI = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		cp_t  cp;
		logic last;
	} res_t;

endpackage

>>> sv/soft_hyphen_transition_inserter.sv
// soft_hyphen_transition_inserter: inserts soft hyphens at first-set to second-set transitions
// depends on shti_pkg

// A character stream enters one transaction per cycle unless in_stall holds it. Each accepted
// character is held in an input stage, then evaluated against the line state in one pass and
// its results (zero to four: an optional soft hyphen, the held back character, and on
// end_of_text an optional hyphen and the character itself) are loaded into a four-entry result
// register that drains one result per cycle while out_stall is low. Output runs one character
// behind input because a hyphen before a character depends on whether the next character is a
// space; end_of_text flushes that lag, marks the final result with out_last and returns the line
// state to reset. Rate: the input stage moves on once the result register is empty or down to
// its last entry being taken; plain text without inserted hyphens runs at one character per
// cycle while out_stall is low, and a character's results pass from the input stage into the
// result register before they reach the output.
// The set bitmaps cover 128 code points from block_base; configuration is taken every cycle
// (cfg_ready is always high) and must only be written while the block is idle.

module soft_hyphen_transition_inserter
	import shti_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration write channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CfgIdxWidth-1:0]      cfg_index,
	input  logic [MaskWidth-1:0]        cfg_data,
	// character input channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [CpWidth-1:0]          code_point,
	input  logic                        end_of_text,
	// result output channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [CpWidth-1:0]          out_code_point,
	output logic                        out_last
);

	// configuration registers
	cp_t                  block_base_q;
	logic [SetSpan-1:0]   first_mask_q;
	logic [SetSpan-1:0]   second_mask_q;

	// input stage
	logic                 valid_s1;
	cp_t                  cp_s1;
	logic                 eot_s1;

	// line and lag state
	logic                 pend_valid_q;
	cp_t                  pend_char_q;
	logic                 pend_cand_q;
	logic                 back_one_q;
	logic                 back_two_q;
	logic                 prior_q;
	logic                 marker_q;

	// result register
	res_t                 rb_q [MaxResults];
	logic [CntWidth-1:0]  cnt_q;

	logic                 in_accept;
	logic                 pop;
	logic                 can_load;
	logic                 advance;

	// set lookup
	logic [CpWidth:0]     diff;
	logic                 in_window;
	logic                 is_space;
	logic                 first_hit;
	logic                 second_hit;

	// next state
	logic                 cand;
	logic                 back_one_n;
	logic                 back_two_n;
	logic                 prior_n;
	logic                 marker_n;

	// result packing
	res_t                 slot_item [MaxResults];
	logic [MaxResults-1:0] slot_en;
	res_t                 rb_n [MaxResults];
	logic [CntWidth-1:0]  cnt_n;

	// ---------------------------------------------------------------------------------------
	// configuration port, never busy
	// ---------------------------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_base_q  <= '0;
			first_mask_q  <= '0;
			second_mask_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BLOCK_BASE:     block_base_q <= cfg_data[CpWidth-1:0];
				REG_FIRST_MASK_LO:  first_mask_q[MaskWidth-1:0] <= cfg_data;
				REG_FIRST_MASK_HI:  first_mask_q[SetSpan-1:MaskWidth] <= cfg_data;
				REG_SECOND_MASK_LO: second_mask_q[MaskWidth-1:0] <= cfg_data;
				REG_SECOND_MASK_HI: second_mask_q[SetSpan-1:MaskWidth] <= cfg_data;
				default: ; // indexes past the register list are dropped
			endcase
		end
	end

	// ---------------------------------------------------------------------------------------
	// handshakes
	// ---------------------------------------------------------------------------------------
	assign out_valid      = (cnt_q != '0);
	assign out_code_point = rb_q[0].cp;
	assign out_last       = rb_q[0].last;
	assign pop            = out_valid && !out_stall;

	// result register takes a new batch once empty or when its final entry leaves now
	assign can_load  = (cnt_q == '0) || ((cnt_q == CntWidth'(1)) && pop);
	assign advance   = valid_s1 && can_load;
	assign in_stall  = valid_s1 && !can_load;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload of the input stage needs no reset
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cp_s1  <= code_point;
			eot_s1 <= end_of_text;
		end
	end

	// ---------------------------------------------------------------------------------------
	// set membership: 128 code points from block_base upward, space never a member
	// ---------------------------------------------------------------------------------------
	assign diff       = {1'b0, cp_s1} - {1'b0, block_base_q};
	assign in_window  = !diff[CpWidth] && (diff[CpWidth-1:SetIdxWidth] == '0);
	assign is_space   = (cp_s1 == ChSpace);
	assign first_hit  = !is_space && in_window && first_mask_q[diff[SetIdxWidth-1:0]];
	assign second_hit = !is_space && in_window && second_mask_q[diff[SetIdxWidth-1:0]];

	// ---------------------------------------------------------------------------------------
	// line state update for the character in the input stage
	// ---------------------------------------------------------------------------------------
	always_comb begin
		cand       = 1'b0;
		back_one_n = back_one_q;
		back_two_n = back_two_q;
		prior_n    = prior_q;
		marker_n   = marker_q;
		if (cp_s1 == ChNewline) begin
			// newline starts a fresh line
			back_one_n = 1'b0;
			back_two_n = 1'b0;
			prior_n    = 1'b0;
			marker_n   = 1'b0;
		end else begin
			if (cp_s1 == ChBackslash) begin
				marker_n = 1'b1;
			end else if (marker_q) begin
				// marker text ends with space or asterisk, first-set flag holds across it
				if (is_space || (cp_s1 == ChStar)) begin
					marker_n = 1'b0;
				end
			end else begin
				cand    = prior_q && second_hit && !back_one_q && !back_two_q;
				prior_n = first_hit;
			end
			back_two_n = back_one_q;
			back_one_n = is_space;
		end
	end

	// ---------------------------------------------------------------------------------------
	// results in order: hyphen, held character, then on end of text hyphen and this character
	// ---------------------------------------------------------------------------------------
	always_comb begin
		slot_item[0] = '{cp: ChShy,       last: 1'b0};
		slot_item[1] = '{cp: pend_char_q, last: 1'b0};
		slot_item[2] = '{cp: ChShy,       last: 1'b0};
		slot_item[3] = '{cp: cp_s1,       last: 1'b1};
		slot_en[0]   = pend_valid_q && pend_cand_q && !is_space;
		slot_en[1]   = pend_valid_q;
		slot_en[2]   = eot_s1 && cand;
		slot_en[3]   = eot_s1;

		cnt_n = '0;
		for (int i = 0; i < MaxResults; i++) begin
			rb_n[i] = '0;
		end
		for (int i = 0; i < MaxResults; i++) begin
			if (slot_en[i]) begin
				rb_n[cnt_n[SlotWidth-1:0]] = slot_item[i];
				cnt_n = cnt_n + CntWidth'(1);
			end
		end
	end

	// ---------------------------------------------------------------------------------------
	// state registers
	// ---------------------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			pend_char_q  <= '0;
			pend_cand_q  <= 1'b0;
			back_one_q   <= 1'b0;
			back_two_q   <= 1'b0;
			prior_q      <= 1'b0;
			marker_q     <= 1'b0;
		end else if (advance) begin
			if (eot_s1) begin
				// end of text returns everything to reset
				pend_valid_q <= 1'b0;
				pend_char_q  <= '0;
				pend_cand_q  <= 1'b0;
				back_one_q   <= 1'b0;
				back_two_q   <= 1'b0;
				prior_q      <= 1'b0;
				marker_q     <= 1'b0;
			end else begin
				pend_valid_q <= 1'b1;
				pend_char_q  <= cp_s1;
				pend_cand_q  <= cand;
				back_one_q   <= back_one_n;
				back_two_q   <= back_two_n;
				prior_q      <= prior_n;
				marker_q     <= marker_n;
			end
		end
	end

	// result register count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (advance) begin
			cnt_q <= cnt_n;
		end else if (pop) begin
			cnt_q <= cnt_q - CntWidth'(1);
		end
	end

	// result entries shift down as each transaction leaves
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < MaxResults; i++) begin
				rb_q[i] <= rb_n[i];
			end
		end else if (pop) begin
			for (int i = 0; i < MaxResults - 1; i++) begin
				rb_q[i] <= rb_q[i+1];
			end
		end
	end

`ifndef SYNTHESIS
	// result count stays within the register depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntWidth'(MaxResults))
		else $error("result count beyond depth");

	// a new batch only lands on an empty or draining result register
	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> ((cnt_q == '0) || ((cnt_q == CntWidth'(1)) && pop)))
		else $error("result batch loaded over live results");

	// while the final result waits, nothing is held back
	a_last_flushed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_last) |-> !pend_valid_q)
		else $error("held character left after end of text");

	// input only stalls behind an occupied input stage
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input stage");

	// a stage that is not moved keeps its character
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(cp_s1) && $stable(eot_s1)))
		else $error("input stage lost its character");
`endif

endmodule
